// ----- rtl/oal_pkg.sv -----
`default_nettype none

package oal_pkg;

  // Widths that the transaction fields fix.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned LEN_W  = 4;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_APPEND  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_REPLACE = 3'd3,
    OP_READ    = 3'd4,
    OP_SEARCH  = 3'd5,
    OP_RMKEY   = 3'd6,
    OP_CLEAR   = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_NOKEY = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_FETCH,
    S_TAKE,
    S_DN_RD,
    S_DN_WR,
    S_SCAN_RD,
    S_SCAN_CMP
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic                     found;
    status_e                  status;
    logic [LEN_W-1:0]         length;
  } rsp_t;

  // Completion of one command, handed from the sequencer to the result register.
  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } fin_t;

endpackage

`default_nettype wire

// ----- rtl/ordered_array_list_engine_unit.sv -----
// Result timing: a clear or a rejected command gives its result strobe in the cycle after
// acceptance; any other command gives it once the sequencer has written, moved, read or
// compared the entries that it needs.
// Commands: one at a time; the single read and single write port of the entry memory
// limit the pace, since each entry moved or compared takes a read state and then a
// write or compare state.
// Reset: the count clears at once; entries are not cleared and the receiver cannot stall.
`default_nettype none

module ordered_array_list_engine_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire oal_pkg::cmd_t cmd_i,
  output logic               busy,
  output logic               done_o,
  output oal_pkg::rsp_t      rsp_o
);
  import oal_pkg::*;

  // Memory address width and count width follow from the depth.
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fin_t              fin;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] rd_data, wr_data;
  logic              done_q;
  rsp_t              rsp_q;

  // The sequencer walks the list one entry at a time through the memory's two ports:
  // shifting entries up for an insert, down for a removal, or comparing them
  // against the key for a search.
  oal_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .cmd_i     (cmd_i),
    .busy_o    (busy),
    .fin_o     (fin),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  // Entry store with a registered read, so read data arrives in the cycle after the read.
  oal_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // Result register: each transaction is shown for exactly one cycle. The
  // sequencer is already idle in that cycle, so a new command can be taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= fin.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin.valid) begin
      rsp_q <= fin.rsp;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // A result is only ever shown once the sequencer has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobe while the sequencer is busy");

  // Every accepted command either keeps the block busy or completes at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither in progress nor completed");

  // A failed command never returns data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status != STAT_OK) |-> (rsp_o.data_out == '0 && !rsp_o.found))
    else $error("error result carries data or a match");

endmodule

`default_nettype wire

// ----- rtl/oal_mem.sv -----
`default_nettype none

module oal_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  wire logic                        clk_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AW-1:0]               rd_addr_i,
  output logic      [oal_pkg::DATA_W-1:0]  rd_data_o,
  input  wire logic                        wr_en_i,
  input  wire logic [AW-1:0]               wr_addr_i,
  input  wire logic [oal_pkg::DATA_W-1:0]  wr_data_i
);
  import oal_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/oal_ctrl.sv -----
`default_nettype none

module oal_ctrl #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3,
  parameter int unsigned CW    = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire oal_pkg::cmd_t               cmd_i,
  output logic                             busy_o,
  output oal_pkg::fin_t                    fin_o,
  output logic                             rd_en_o,
  output logic      [AW-1:0]               rd_addr_o,
  input  wire logic [oal_pkg::DATA_W-1:0]  rd_data_i,
  output logic                             wr_en_o,
  output logic      [AW-1:0]               wr_addr_o,
  output logic      [oal_pkg::DATA_W-1:0]  wr_data_o
);
  import oal_pkg::*;

  localparam int unsigned EW = (CW > POS_W) ? CW : POS_W;

  state_e            state_q, state_d;
  op_e               op_q, op_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     tgt_q, tgt_d;
  logic [CW-1:0]     where_q, where_d;
  logic              hit_q, hit_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] data_q, data_d;

  logic          accept;
  logic          full;
  logic [EW-1:0] pos_ext, cnt_ext;
  logic          pos_gt_cnt, pos_ge_cnt, pos_eq_cnt;
  logic [CW-1:0] idx_dec, idx_inc, idx_inc2, tgt_inc;
  logic          up_last, match, scan_last, hit_any, dn_take_more, dn_more;

  assign accept     = start_i && (state_q == S_IDLE);
  assign full       = (cnt_q == CW'(DEPTH));
  assign pos_ext    = EW'(cmd_i.position);
  assign cnt_ext    = EW'(cnt_q);
  assign pos_gt_cnt = pos_ext > cnt_ext;
  assign pos_ge_cnt = pos_ext >= cnt_ext;
  assign pos_eq_cnt = pos_ext == cnt_ext;
  assign idx_dec    = idx_q - CW'(1);
  assign idx_inc    = idx_q + CW'(1);
  assign idx_inc2   = idx_inc + CW'(1);
  assign tgt_inc    = tgt_q + CW'(1);
  assign up_last    = (idx_dec == tgt_q);
  assign match      = (rd_data_i == key_q);
  assign scan_last  = (idx_inc == cnt_q);
  assign hit_any    = hit_q || match;
  assign dn_take_more = (tgt_inc < cnt_q);
  assign dn_more    = (idx_inc2 < cnt_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i.op)
            OP_INSERT: begin
              if (!full && !pos_gt_cnt) begin
                state_d = pos_eq_cnt ? S_PUT : S_UP_RD;
              end
            end
            OP_APPEND: begin
              if (!full) begin
                state_d = S_PUT;
              end
            end
            OP_REPLACE: begin
              if (!pos_ge_cnt) begin
                state_d = S_PUT;
              end
            end
            OP_REMOVE, OP_READ: begin
              if (!pos_ge_cnt) begin
                state_d = S_FETCH;
              end
            end
            OP_SEARCH, OP_RMKEY: begin
              if (cnt_q != '0) begin
                state_d = S_SCAN_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_UP_RD:    state_d = S_UP_WR;
      S_UP_WR:    state_d = up_last ? S_PUT : S_UP_RD;
      S_PUT:      state_d = S_IDLE;
      S_FETCH:    state_d = S_TAKE;
      S_TAKE: begin
        if (op_q != OP_READ && dn_take_more) begin
          state_d = S_DN_RD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DN_RD:    state_d = S_DN_WR;
      S_DN_WR:    state_d = dn_more ? S_DN_RD : S_IDLE;
      S_SCAN_RD:  state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (!scan_last) begin
          state_d = S_SCAN_RD;
        end else if (hit_any && op_q == OP_RMKEY) begin
          state_d = S_FETCH;
        end else begin
          state_d = S_IDLE;
        end
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath control, memory port and completion.
  always_comb begin
    op_d      = op_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    tgt_d     = tgt_q;
    where_d   = where_q;
    hit_d     = hit_q;
    key_d     = key_q;
    data_d    = data_q;
    rd_en_o   = 1'b0;
    rd_addr_o = idx_q[AW-1:0];
    wr_en_o   = 1'b0;
    wr_addr_o = tgt_q[AW-1:0];
    wr_data_o = key_q;
    fin_o     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = cmd_i.op;
          key_d  = cmd_i.value;
          hit_d  = 1'b0;
          data_d = '0;
          case (cmd_i.op)
            OP_INSERT: begin
              if (full) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = STAT_FULL;
              end else if (pos_gt_cnt) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = STAT_RANGE;
              end else begin
                tgt_d = CW'(cmd_i.position);
                idx_d = cnt_q;
              end
            end
            OP_APPEND: begin
              if (full) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = STAT_FULL;
              end else begin
                tgt_d = cnt_q;
              end
            end
            OP_REMOVE, OP_REPLACE, OP_READ: begin
              if (pos_ge_cnt) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = STAT_RANGE;
              end else begin
                tgt_d = CW'(cmd_i.position);
              end
            end
            OP_SEARCH, OP_RMKEY: begin
              if (cnt_q == '0) begin
                fin_o.valid      = 1'b1;
                fin_o.rsp.status = STAT_NOKEY;
              end else begin
                idx_d = '0;
              end
            end
            default: begin
              // Clear: entries beyond the count are never read back.
              cnt_d       = '0;
              fin_o.valid = 1'b1;
            end
          endcase
        end
      end
      S_UP_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = idx_dec[AW-1:0];
      end
      S_UP_WR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q[AW-1:0];
        wr_data_o = rd_data_i;
        idx_d     = idx_dec;
      end
      S_PUT: begin
        wr_en_o     = 1'b1;
        fin_o.valid = 1'b1;
        if (op_q != OP_REPLACE) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      S_FETCH: begin
        rd_en_o   = 1'b1;
        rd_addr_o = tgt_q[AW-1:0];
      end
      S_TAKE: begin
        data_d = rd_data_i;
        idx_d  = tgt_q;
        if (op_q == OP_READ) begin
          fin_o.valid         = 1'b1;
          fin_o.rsp.data_out  = rd_data_i;
        end else if (!dn_take_more) begin
          cnt_d               = cnt_q - CW'(1);
          fin_o.valid         = 1'b1;
          fin_o.rsp.data_out  = rd_data_i;
          fin_o.rsp.found     = (op_q == OP_RMKEY);
        end
      end
      S_DN_RD: begin
        rd_en_o   = 1'b1;
        rd_addr_o = idx_inc[AW-1:0];
      end
      S_DN_WR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = idx_q[AW-1:0];
        wr_data_o = rd_data_i;
        idx_d     = idx_inc;
        if (!dn_more) begin
          cnt_d              = cnt_q - CW'(1);
          fin_o.valid        = 1'b1;
          fin_o.rsp.data_out = data_q;
          fin_o.rsp.found    = (op_q == OP_RMKEY);
        end
      end
      S_SCAN_RD: begin
        rd_en_o = 1'b1;
      end
      S_SCAN_CMP: begin
        // The last match wins, so a later hit overwrites the recorded index.
        if (match) begin
          hit_d   = 1'b1;
          where_d = idx_q;
        end
        if (!scan_last) begin
          idx_d = idx_inc;
        end else if (!hit_any) begin
          fin_o.valid      = 1'b1;
          fin_o.rsp.status = STAT_NOKEY;
        end else if (op_q == OP_SEARCH) begin
          fin_o.valid     = 1'b1;
          fin_o.rsp.found = 1'b1;
        end else begin
          tgt_d = match ? idx_q : where_q;
        end
      end
      default: begin
        fin_o = '0;
      end
    endcase

    fin_o.rsp.length = LEN_W'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    tgt_q   <= tgt_d;
    where_q <= where_d;
    hit_q   <= hit_d;
    key_q   <= key_d;
    data_q  <= data_d;
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- tb/ordered_array_list_engine_unit_test.sv -----
module ordered_array_list_engine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import oal_pkg::*;

  // The list is built with eight entries; the predictor below keeps a list of the same size.
  localparam int unsigned LIST_DEPTH = 8;
  // The sender may sit idle for a while, so the watchdog limit on cycles in which neither
  // side moves anything lies well above the time that any one transaction takes.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // A key removal on a full list is the slowest command.
  localparam int unsigned SETTLE_CYCLES = 40;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  cmd_t  cmd_i;
  logic  busy;
  logic  done_o;
  rsp_t  rsp_o;

  // The predicted contents of the list and the number of entries held.
  logic signed [DATA_W-1:0] slots [LIST_DEPTH];
  int unsigned              held;

  // Outcomes worked out at acceptance, waiting for the block to deliver them.
  rsp_t        awaited_outcomes [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned sender_idle_pct;

  ordered_array_list_engine_unit #(
    .DEPTH (LIST_DEPTH)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Removes the entry at the given position, closing the gap by moving the later entries
  // down by one, and hands back the entry that was removed.
  function automatic logic signed [DATA_W-1:0] take_slot(input int unsigned pos);
    logic signed [DATA_W-1:0] item;
    int unsigned              i;
    item = slots[pos];
    for (i = pos; i + 1 < held; i++) begin
      slots[i] = slots[i + 1];
    end
    held--;
    return item;
  endfunction

  // Applies one command to the predicted list and returns the result that the block must
  // give for it. A failing command leaves the list exactly as it was.
  function automatic rsp_t list_command_outcome(input cmd_t c);
    rsp_t        r;
    int unsigned pos;
    int          hit_at;
    int unsigned i;
    r        = '0;
    r.status = STAT_OK;
    pos      = 32'(c.position);
    case (c.op)
      OP_INSERT, OP_APPEND: begin
        if (c.op == OP_APPEND) begin
          pos = held;
        end
        // A full list is reported before any position check.
        if (held >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else if (pos > held) begin
          r.status = STAT_RANGE;
        end else begin
          for (i = held; i > pos; i--) begin
            slots[i] = slots[i - 1];
          end
          slots[pos] = c.value;
          held++;
        end
      end
      OP_REMOVE: begin
        if (pos >= held) begin
          r.status = STAT_RANGE;
        end else begin
          r.data_out = take_slot(pos);
        end
      end
      OP_REPLACE: begin
        if (pos >= held) begin
          r.status = STAT_RANGE;
        end else begin
          slots[pos] = c.value;
        end
      end
      OP_READ: begin
        if (pos >= held) begin
          r.status = STAT_RANGE;
        end else begin
          r.data_out = slots[pos];
        end
      end
      OP_SEARCH, OP_RMKEY: begin
        // The scan covers every entry held, the last one included, and the match with the
        // highest position is the one that counts.
        hit_at = -1;
        for (i = 0; i < held; i++) begin
          if (slots[i] == c.value) begin
            hit_at = i;
          end
        end
        if (hit_at < 0) begin
          r.status = STAT_NOKEY;
        end else begin
          r.found = 1'b1;
          if (c.op == OP_RMKEY) begin
            r.data_out = take_slot(hit_at);
          end
        end
      end
      default: begin
        for (i = 0; i < LIST_DEPTH; i++) begin
          slots[i] = '0;
        end
        held = 0;
      end
    endcase
    r.length = LEN_W'(held);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) begin
      $display("[%0t] %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Sends one command. The sender may first sit idle for some cycles; start is then held
  // high until the block takes the transaction, and the expected outcome is worked out at
  // the very edge at which it is accepted. Start is left high afterwards, so that a command
  // sent straight after this one follows without a gap.
  task automatic issue_command(input op_e op, input int unsigned pos,
                               input logic [DATA_W-1:0] val);
    cmd_t c;
    c.op       = op;
    c.position = pos[POS_W-1:0];
    c.value    = val;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    awaited_outcomes.push_back(list_command_outcome(c));
  endtask

  // Holds the sender back until every outstanding result has come back. The first edge is
  // always waited for, so that start is never assigned twice in one time step.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (awaited_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Picks a random command. Positions mostly lie within the list or just past its end,
  // values come often from a small pool so that duplicates arise, and keys are often taken
  // from the entries held so that searches and key removals find something.
  task automatic issue_random_command();
    op_e                 op;
    int unsigned         pos;
    logic [DATA_W-1:0]   val;
    int unsigned         pick;
    pick = $urandom_range(99);
    if (pick < 16) begin
      op = OP_INSERT;
    end else if (pick < 28) begin
      op = OP_APPEND;
    end else if (pick < 40) begin
      op = OP_REMOVE;
    end else if (pick < 50) begin
      op = OP_REPLACE;
    end else if (pick < 62) begin
      op = OP_READ;
    end else if (pick < 76) begin
      op = OP_SEARCH;
    end else if (pick < 97) begin
      op = OP_RMKEY;
    end else begin
      op = OP_CLEAR;
    end
    if ($urandom_range(99) < 85) begin
      pos = $urandom_range(held);
    end else begin
      pos = $urandom_range(15);
    end
    pick = $urandom_range(99);
    if (pick < 40) begin
      val = $urandom;
    end else if (pick < 75) begin
      val = $urandom_range(6) - 3;
    end else if (pick < 85) begin
      val = pick[0] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      val = $urandom;
    end
    if ((op == OP_SEARCH || op == OP_RMKEY) && held != 0 && $urandom_range(99) < 60) begin
      val = slots[$urandom_range(held - 1)];
    end
    issue_command(op, pos, val);
  endtask

  // Commands on an empty list: all but the clear must fail, and none changes the list.
  task automatic test_empty_list();
    issue_command(OP_CLEAR, 0, 32'd0);
    issue_command(OP_READ, 0, 32'd0);
    issue_command(OP_RMKEY, 0, 32'd0);
    issue_command(OP_SEARCH, 0, 32'd0);
  endtask

  // Builds a full list from both extremes of the value range and a few duplicates, the last
  // insert landing in the last free slot, then tries to grow it beyond its size. The insert
  // on the full list also carries a bad position, which the full check must win over.
  task automatic test_fill_to_capacity();
    issue_command(OP_INSERT, 1, 32'd7);
    issue_command(OP_INSERT, 0, 32'h8000_0000);
    issue_command(OP_APPEND, 0, 32'h7fff_ffff);
    issue_command(OP_INSERT, 2, 32'hffff_ffff);
    issue_command(OP_INSERT, 1, 32'd5);
    issue_command(OP_APPEND, 0, 32'd5);
    issue_command(OP_APPEND, 0, 32'd0);
    issue_command(OP_APPEND, 0, 32'd5);
    issue_command(OP_INSERT, 7, 32'd9);
    issue_command(OP_INSERT, 15, 32'd1);
    issue_command(OP_APPEND, 0, 32'd1);
  endtask

  // The key held in the final entry must be found, the duplicate at the highest position
  // must be the one removed, and a missing key must be reported by both lookups.
  task automatic test_key_lookup();
    issue_command(OP_SEARCH, 0, 32'd9);
    issue_command(OP_RMKEY, 0, 32'd5);
    issue_command(OP_SEARCH, 0, 32'd12345);
    issue_command(OP_RMKEY, 0, 32'd12345);
  endtask

  // Replace, read and remove by position, with positions just past the end and at the top
  // of the field, then a clear of a list that holds entries.
  task automatic test_positional_edits();
    issue_command(OP_REPLACE, 0, 32'd1);
    issue_command(OP_READ, 15, 32'd0);
    issue_command(OP_REMOVE, 0, 32'd0);
    issue_command(OP_REMOVE, held, 32'd0);
    issue_command(OP_READ, held - 1, 32'd0);
    issue_command(OP_CLEAR, 0, 32'd0);
  endtask

  // Random commands with the given chance that the sender idles before each one. Now and
  // then the sender waits for every outstanding result, so that a command also starts on a
  // block that has long been idle.
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned count);
    int unsigned n;
    sender_idle_pct = idle_pct;
    for (n = 0; n < count; n++) begin
      issue_random_command();
      if ($urandom_range(39) == 0) begin
        drain_results();
      end
    end
  endtask

  // Every result is compared with the oldest outcome still awaited. The same block keeps
  // the watchdog, which counts cycles in which no transaction moves in either direction.
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_outcomes.size() == 0) begin
          report_mismatch($sformatf("result with nothing outstanding: data %0h status %0d",
                                    rsp_o.data_out, rsp_o.status));
        end else begin
          want = awaited_outcomes.pop_front();
          if (rsp_o.data_out !== want.data_out) begin
            report_mismatch($sformatf("data_out: got %0h, expected %0h",
                                      rsp_o.data_out, want.data_out));
          end
          if (rsp_o.found !== want.found) begin
            report_mismatch($sformatf("found: got %0b, expected %0b", rsp_o.found, want.found));
          end
          if (rsp_o.status !== want.status) begin
            report_mismatch($sformatf("status: got %0d, expected %0d",
                                      rsp_o.status, want.status));
          end
          if (rsp_o.length !== want.length) begin
            report_mismatch($sformatf("length: got %0d, expected %0d",
                                      rsp_o.length, want.length));
          end
        end
      end
      if (done_o || (start && !busy)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("ordered_array_list_engine_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    held            = 0;
    mismatches      = 0;
    quiet_cycles    = 0;
    sender_idle_pct = 0;
    foreach (slots[i]) begin
      slots[i] = '0;
    end
    rst_ni <= 1'b0;
    start  <= 1'b0;
    cmd_i  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The directed part runs back to back; the random part then goes through the sender
    // phases. The receiver cannot hold results off, so only the sender idles.
    test_empty_list();
    test_fill_to_capacity();
    test_key_lookup();
    test_positional_edits();
    test_random_traffic(0, 175);
    test_random_traffic(82, 175);
    test_random_traffic(9, 175);

    // Let every outstanding result arrive, then watch a while longer for stray strobes.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ordered_array_list_engine_unit: match");
    end else begin
      $display("ordered_array_list_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/oal_pkg.sv
rtl/oal_mem.sv
rtl/oal_ctrl.sv
rtl/ordered_array_list_engine_unit.sv
tb/ordered_array_list_engine_unit_test.sv
